/* design/mspid_pkg.sv */
// ----------------------------------------------------------------------------
// mspid_pkg
// Types and constants shared by the motor speed PID controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mspid_pkg;

   // Count jump beyond which a step against the commanded direction is a wrap.
   localparam int WRAP_JUMP = 16000;

   // Limits of the 15-bit signed measured speed.
   localparam int SPEED_MAX = 16383;
   localparam int SPEED_MIN = -16384;

   // Result word layout.
   localparam int RSP_DATA_W = 40;
   localparam int RSP_FIELD_W = 33;

   // Register file.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int GAIN_W = 16;
   localparam logic [GAIN_W-1:0] MAX_PWM_RESET = 16'hFFFF;

   localparam logic [2:0] REG_KP_GAIN   = 3'd0;
   localparam logic [2:0] REG_KI_GAIN   = 3'd1;
   localparam logic [2:0] REG_KD_GAIN   = 3'd2;
   localparam logic [2:0] REG_MAX_PWM   = 3'd3;
   localparam logic [2:0] REG_DEADBAND  = 3'd4;

   typedef struct packed {
      logic [GAIN_W-1:0] kp_gain;
      logic [GAIN_W-1:0] ki_gain;
      logic [GAIN_W-1:0] kd_gain;
      logic [GAIN_W-1:0] max_pwm;
      logic [GAIN_W-1:0] deadband;
   } cfg_type;

   typedef struct packed {
      logic advance;   // the word in the input register moves to the result register
      logic clear;     // that word is a controller reset
   } step_ctl_type;

endpackage

`default_nettype wire

/* design/mspid_csr.sv */
// ----------------------------------------------------------------------------
// mspid_csr
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module mspid_csr (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_psel,
   input  wire logic                                    csr_penable,
   input  wire logic                                    csr_pwrite,
   input  wire logic [mspid_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire logic [mspid_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic      [mspid_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output mspid_pkg::cfg_type                           cfg
);

   mspid_pkg::cfg_type cfg_ff;
   logic [2:0]         reg_index;
   logic               wr_en;
   logic [mspid_pkg::GAIN_W-1:0] wr_value;
   logic [mspid_pkg::GAIN_W-1:0] rd_value;

   assign reg_index = csr_paddr[4:2];
   assign wr_en     = csr_psel && csr_penable && csr_pwrite;
   assign wr_value  = csr_pwdata[mspid_pkg::GAIN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_gain   <= '0;
         cfg_ff.ki_gain   <= '0;
         cfg_ff.kd_gain   <= '0;
         cfg_ff.max_pwm   <= mspid_pkg::MAX_PWM_RESET;
         cfg_ff.deadband  <= '0;
      end else if (wr_en) begin
         case (reg_index)
            mspid_pkg::REG_KP_GAIN:   cfg_ff.kp_gain   <= wr_value;
            mspid_pkg::REG_KI_GAIN:   cfg_ff.ki_gain   <= wr_value;
            mspid_pkg::REG_KD_GAIN:   cfg_ff.kd_gain   <= wr_value;
            mspid_pkg::REG_MAX_PWM:   cfg_ff.max_pwm   <= wr_value;
            mspid_pkg::REG_DEADBAND:  cfg_ff.deadband  <= wr_value;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         mspid_pkg::REG_KP_GAIN:   rd_value = cfg_ff.kp_gain;
         mspid_pkg::REG_KI_GAIN:   rd_value = cfg_ff.ki_gain;
         mspid_pkg::REG_KD_GAIN:   rd_value = cfg_ff.kd_gain;
         mspid_pkg::REG_MAX_PWM:   rd_value = cfg_ff.max_pwm;
         mspid_pkg::REG_DEADBAND:  rd_value = cfg_ff.deadband;
         default:                  rd_value = '0;
      endcase
   end

   assign csr_prdata = {{(mspid_pkg::CSR_DATA_W-mspid_pkg::GAIN_W){1'b0}}, rd_value};
   assign cfg        = cfg_ff;

endmodule

`default_nettype wire

/* design/mspid_speed.sv */
// ----------------------------------------------------------------------------
// mspid_speed
// Measured speed from the encoder count delta, with wrap-around correction.
// ----------------------------------------------------------------------------
`default_nettype none

module mspid_speed #(
   parameter int COUNT_BITS = 14
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  mspid_pkg::step_ctl_type      ctl,
   input  wire logic [COUNT_BITS-1:0]   count_sample,
   input  wire logic                    reverse,
   output logic signed [14:0]           speed,
   output logic signed [14:0]           last_speed
);

   // Wide enough for the jump constant and for a reverse wrap of twice the modulus.
   localparam int SW = ((COUNT_BITS > 14) ? COUNT_BITS : 14) + 3;

   logic [COUNT_BITS-1:0] last_count_ff;
   logic signed [14:0]    last_speed_ff;
   logic signed [SW-1:0]  cur_s;
   logic signed [SW-1:0]  prev_s;
   logic signed [SW-1:0]  up;
   logic signed [SW-1:0]  dn;
   logic signed [SW-1:0]  modulus;
   logic signed [SW-1:0]  jump;
   logic signed [SW-1:0]  raw;
   logic signed [SW-1:0]  smax;
   logic signed [SW-1:0]  smin;

   assign cur_s   = $signed({{(SW-COUNT_BITS){1'b0}}, count_sample});
   assign prev_s  = $signed({{(SW-COUNT_BITS){1'b0}}, last_count_ff});
   assign up      = cur_s - prev_s;
   assign dn      = prev_s - cur_s;
   assign modulus = $signed({{(SW-1){1'b0}}, 1'b1} << COUNT_BITS);
   assign jump    = $signed(SW'(mspid_pkg::WRAP_JUMP));
   assign smax    = $signed(SW'(mspid_pkg::SPEED_MAX));
   assign smin    = $signed(SW'(mspid_pkg::SPEED_MIN));

   always_comb begin
      if (!reverse && (dn > jump)) begin
         raw = modulus + up;
      end else if (reverse && (up > jump)) begin
         raw = cur_s - modulus - prev_s;
      end else begin
         raw = up;
      end

      if (raw > smax) begin
         speed = smax[14:0];
      end else if (raw < smin) begin
         speed = smin[14:0];
      end else begin
         speed = raw[14:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (ctl.advance && ctl.clear)) begin
         last_count_ff <= '0;
         last_speed_ff <= '0;
      end else if (ctl.advance) begin
         last_count_ff <= count_sample;
         last_speed_ff <= speed;
      end
   end

   assign last_speed = last_speed_ff;

endmodule

`default_nettype wire

/* design/mspid_law.sv */
// ----------------------------------------------------------------------------
// mspid_law
// PID control law with a clamped integrator, output clamp and deadband.
// ----------------------------------------------------------------------------
`default_nettype none

module mspid_law (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  mspid_pkg::step_ctl_type   ctl,
   input  mspid_pkg::cfg_type        cfg,
   input  wire logic signed [23:0]   target_speed,
   input  wire logic signed [14:0]   speed,
   input  wire logic signed [14:0]   last_speed,
   output logic [15:0]               duty,
   output logic                      brake
);

   localparam logic signed [41:0] ZERO = '0;

   logic signed [39:0] integrator_ff;
   logic signed [24:0] err;
   logic signed [16:0] kp_s;
   logic signed [16:0] ki_s;
   logic signed [16:0] kd_s;
   logic signed [41:0] prop_prod;
   logic signed [41:0] inc_prod;
   logic signed [41:0] prop;
   logic signed [41:0] inc;
   logic signed [41:0] integ_sum;
   logic signed [41:0] integ_new;
   logic signed [41:0] maxq;
   logic signed [41:0] lim_hi;
   logic signed [41:0] lim_lo;
   logic signed [15:0] dspeed;
   logic signed [32:0] deriv;
   logic signed [41:0] sum;
   logic signed [41:0] sum_cl;
   logic [15:0]        duty_raw;

   // Error in Q.8 pulses: target minus measured speed scaled by 256.
   assign err  = $signed({target_speed[23], target_speed})
               - $signed({{2{speed[14]}}, speed, 8'b0});
   assign kp_s = $signed({1'b0, cfg.kp_gain});
   assign ki_s = $signed({1'b0, cfg.ki_gain});
   assign kd_s = $signed({1'b0, cfg.kd_gain});

   assign prop_prod = kp_s * err;
   assign inc_prod  = ki_s * err;
   // Arithmetic shift gives division by 256 rounded towards minus infinity.
   assign prop      = prop_prod >>> 8;
   assign inc       = inc_prod >>> 8;

   assign integ_sum = $signed({{2{integrator_ff[39]}}, integrator_ff}) + inc;
   assign maxq      = $signed({18'b0, cfg.max_pwm, 8'b0});
   assign lim_hi    = (maxq > prop) ? (maxq - prop) : ZERO;
   assign lim_lo    = (prop > ZERO) ? -prop : ZERO;

   always_comb begin
      if (integ_sum > lim_hi) begin
         integ_new = lim_hi;
      end else if (integ_sum < lim_lo) begin
         integ_new = lim_lo;
      end else begin
         integ_new = integ_sum;
      end
   end

   assign dspeed = $signed({speed[14], speed}) - $signed({last_speed[14], last_speed});
   assign deriv  = kd_s * dspeed;
   assign sum    = prop + $signed({{9{deriv[32]}}, deriv}) + integ_new;

   always_comb begin
      if (sum > maxq) begin
         sum_cl = maxq;
      end else if (sum < ZERO) begin
         sum_cl = ZERO;
      end else begin
         sum_cl = sum;
      end
      duty_raw = sum_cl[23:8];
      if (ctl.clear || (duty_raw < cfg.deadband)) begin
         duty = '0;
      end else begin
         duty = duty_raw;
      end
   end

   assign brake = (duty == '0);

   always_ff @(posedge clock) begin
      if (reset || (ctl.advance && ctl.clear)) begin
         integrator_ff <= '0;
      end else if (ctl.advance) begin
         integrator_ff <= integ_new[39:0];
      end
   end

endmodule

`default_nettype wire

/* design/motor_speed_pid.sv */
// A word accepted at a clock edge is held in the input register and moves to the
// result register, raising rsp_tvalid, when that register is empty or being read.
// Throughput: one word per cycle unless the result side stalls; the whole
// control law for a tick is one combinational pass between the two registers.
// Reset clears both valid flags, the controller state and the registers
// (max_pwm to 65535, all others to zero).
// ----------------------------------------------------------------------------
// motor_speed_pid
// Speed PID controller for a brushed motor with a quadrature encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_pid #(
   parameter int COUNT_BITS = 14,
   localparam int ReqDataW = ((COUNT_BITS + 25 + 7) / 8) * 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input word.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // count_sample, reverse, target_speed
   input  wire logic [ReqDataW-1:0]                 req_tdata,
   // op
   input  wire logic                                req_tuser,
   // Result word.
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // duty, drive_reverse, brake, measured_speed
   output logic [mspid_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // Configuration port.
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [mspid_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [mspid_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [mspid_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                     csr_pready
);

   mspid_pkg::cfg_type      cfg;
   mspid_pkg::step_ctl_type ctl;

   logic                    in_valid_ff;
   logic                    in_op_ff;
   logic [COUNT_BITS-1:0]   in_count_ff;
   logic                    in_rev_ff;
   logic signed [23:0]      in_target_ff;

   logic                    out_valid_ff;
   logic [15:0]             out_duty_ff;
   logic                    out_rev_ff;
   logic                    out_brake_ff;
   logic signed [14:0]      out_speed_ff;

   logic                    advance;
   logic signed [14:0]      speed;
   logic signed [14:0]      last_speed;
   logic [15:0]             duty;
   logic                    brake;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign ctl.advance = advance;
   assign ctl.clear   = in_op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff     <= req_tuser;
         in_count_ff  <= req_tdata[COUNT_BITS-1:0];
         in_rev_ff    <= req_tdata[COUNT_BITS];
         in_target_ff <= $signed(req_tdata[COUNT_BITS+24:COUNT_BITS+1]);
      end
   end

   mspid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   mspid_speed #(
      .COUNT_BITS (COUNT_BITS)
   ) u_speed (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .count_sample (in_count_ff),
      .reverse      (in_rev_ff),
      .speed        (speed),
      .last_speed   (last_speed)
   );

   mspid_law u_law (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .cfg          (cfg),
      .target_speed (in_target_ff),
      .speed        (speed),
      .last_speed   (last_speed),
      .duty         (duty),
      .brake        (brake)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_duty_ff  <= duty;
         out_brake_ff <= brake;
         out_rev_ff   <= in_op_ff ? 1'b0 : in_rev_ff;
         out_speed_ff <= in_op_ff ? 15'sd0 : speed;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(mspid_pkg::RSP_DATA_W-mspid_pkg::RSP_FIELD_W){1'b0}},
                        out_speed_ff, out_brake_ff, out_rev_ff, out_duty_ff};
   assign csr_pready = 1'b1;

endmodule

`default_nettype wire

/* bench/pid_checker.sv */
// ----------------------------------------------------------------------------
// pid_checker
// Watches the word, result and register ports of the motor speed PID, keeps
// its own copy of the controller state and registers, predicts the drive
// command for every accepted word and compares it with the result stream.
// ----------------------------------------------------------------------------
module pid_checker
   import mspid_pkg::*;
#(
   parameter int COUNT_BITS = 14,
   parameter int REQ_W = 40
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // count_sample, reverse, target_speed
   input  logic [REQ_W-1:0]      req_tdata,
   // op (high clears the controller state)
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // duty, drive_reverse, brake, measured_speed
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatches,
   output int                    drives_outstanding,
   output int                    words_seen,
   output int                    resets_seen,
   output int                    wraps_seen,
   output int                    brakes_seen,
   output int                    drives_compared
);
   timeunit 1ns;
   timeprecision 1ps;

   // Packed so that duty sits in the lowest bits, as on the result bus.
   typedef struct packed {
      logic signed [14:0] measured_speed;
      logic               brake;
      logic               drive_reverse;
      logic [15:0]        duty;
   } drive_cmd_type;

   longint gain_p, gain_i, gain_d, duty_ceiling, deadband_lim;
   longint prev_count, prev_speed, integrator;
   drive_cmd_type expected_drives[$];

   function automatic drive_cmd_type predict_drive(input logic clear,
                                                   input logic [COUNT_BITS-1:0] count,
                                                   input logic rev,
                                                   input logic signed [23:0] target_q8);
      longint modulus, now, target, speed, err, prop, deriv, ceil_q8, hi, lo, total;
      drive_cmd_type cmd;
      cmd = '0;
      if (clear) begin
         prev_count = 0;
         prev_speed = 0;
         integrator = 0;
         cmd.brake = 1'b1;
         resets_seen++;
         return cmd;
      end
      modulus = longint'(1) << COUNT_BITS;
      now = longint'(count);
      target = longint'(target_q8);

      // A large step against the commanded direction is taken as a counter wrap.
      if (!rev && now < prev_count && prev_count - now > WRAP_JUMP) begin
         speed = modulus - prev_count + now;
         wraps_seen++;
      end else if (rev && now > prev_count && now - prev_count > WRAP_JUMP) begin
         speed = now - modulus - prev_count;
         wraps_seen++;
      end else begin
         speed = now - prev_count;
      end
      if (speed > SPEED_MAX)
         speed = SPEED_MAX;
      else if (speed < SPEED_MIN)
         speed = SPEED_MIN;

      err = target - speed * 256;
      prop = (gain_p * err) >>> 8;
      integrator = integrator + ((gain_i * err) >>> 8);

      // Anti-windup: integrator clamped so prop + integral stays in 0..ceiling when prop does.
      ceil_q8 = duty_ceiling * 256;
      hi = (ceil_q8 > prop) ? ceil_q8 - prop : 0;
      lo = (prop > 0) ? -prop : 0;
      if (integrator > hi)
         integrator = hi;
      else if (integrator < lo)
         integrator = lo;

      deriv = gain_d * (speed - prev_speed);
      total = prop + deriv + integrator;
      prev_count = now;
      prev_speed = speed;

      if (total > ceil_q8)
         total = ceil_q8;
      else if (total < 0)
         total = 0;
      total = total >>> 8;
      if (total < deadband_lim)
         total = 0;

      cmd.duty = total[15:0];
      cmd.drive_reverse = rev;
      cmd.brake = (total == 0);
      cmd.measured_speed = speed[14:0];
      return cmd;
   endfunction

   always @(posedge clock) begin
      drive_cmd_type seen, want;
      if (reset) begin
         gain_p = 0;
         gain_i = 0;
         gain_d = 0;
         duty_ceiling = longint'(MAX_PWM_RESET);
         deadband_lim = 0;
         prev_count = 0;
         prev_speed = 0;
         integrator = 0;
         expected_drives.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_KP_GAIN:   gain_p = longint'(csr_pwdata[GAIN_W-1:0]);
               REG_KI_GAIN:   gain_i = longint'(csr_pwdata[GAIN_W-1:0]);
               REG_KD_GAIN:   gain_d = longint'(csr_pwdata[GAIN_W-1:0]);
               REG_MAX_PWM:   duty_ceiling = longint'(csr_pwdata[GAIN_W-1:0]);
               REG_DEADBAND:  deadband_lim = longint'(csr_pwdata[GAIN_W-1:0]);
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            words_seen++;
            expected_drives.push_back(predict_drive(req_tuser,
                                                    req_tdata[COUNT_BITS-1:0],
                                                    req_tdata[COUNT_BITS],
                                                    req_tdata[COUNT_BITS+24:COUNT_BITS+1]));
         end

         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[RSP_FIELD_W-1:0];
            if (expected_drives.size() == 0) begin
               mismatches++;
               $display("%0t ns: result word expected none, got %h", $time, seen);
            end else begin
               want = expected_drives.pop_front();
               drives_compared++;
               if (seen.brake)
                  brakes_seen++;
               if (seen !== want)
                  mismatches++;
               if (seen.duty !== want.duty)
                  $display("%0t ns: duty expected %0d, got %0d",
                           $time, want.duty, seen.duty);
               if (seen.drive_reverse !== want.drive_reverse)
                  $display("%0t ns: drive_reverse expected %0b, got %0b",
                           $time, want.drive_reverse, seen.drive_reverse);
               if (seen.brake !== want.brake)
                  $display("%0t ns: brake expected %0b, got %0b",
                           $time, want.brake, seen.brake);
               if (seen.measured_speed !== want.measured_speed)
                  $display("%0t ns: measured_speed expected %0d, got %0d",
                           $time, want.measured_speed, seen.measured_speed);
            end
         end
      end
      drives_outstanding <= expected_drives.size();
   end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the motor speed PID with directed corner cases and then with runs of
// simulated encoder motion under many register settings, with random idling
// on both streams; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   import mspid_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_BITS = 14;
   localparam int REQ_W = ((COUNT_BITS + 25 + 7) / 8) * 8;
   localparam int LONG_HOLD = 220;
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatches, drives_outstanding, words_seen, resets_seen;
   int wraps_seen, brakes_seen, drives_compared;
   int settings_applied = 0;
   int stall_seq = 0;
   bit calm_rsp = 1'b0;
   int enc_pos = 0;
   int motor_rate = 0;

   motor_speed_pid #(.COUNT_BITS(COUNT_BITS)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   pid_checker #(.COUNT_BITS(COUNT_BITS), .REQ_W(REQ_W)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .mismatches(mismatches), .drives_outstanding(drives_outstanding),
      .words_seen(words_seen), .resets_seen(resets_seen), .wraps_seen(wraps_seen),
      .brakes_seen(brakes_seen), .drives_compared(drives_compared)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_gain();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 16'h0000;
      if (r == 1)
         return 16'hFFFF;
      if (r < 7)
         return 16'($urandom_range(0, 1024));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] pick_ceiling();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 16'h0000;
      if (r == 1)
         return 16'hFFFF;
      if (r < 4)
         return 16'($urandom_range(1, 255));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] pick_deadband();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return 16'h0000;
      if (r == 4)
         return 16'hFFFF;
      if (r < 8)
         return 16'($urandom_range(0, 2000));
      return 16'($urandom_range(0, 65535));
   endfunction

   // The upper half of the data bus carries junk; the registers are 16 bits.
   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      logic [15:0] junk;
      junk = 16'($urandom_range(0, 65535));
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {junk, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] kp, input logic [15:0] ki,
                                 input logic [15:0] kd, input logic [15:0] ceiling,
                                 input logic [15:0] deadband);
      write_reg(REG_KP_GAIN, kp);
      write_reg(REG_KI_GAIN, ki);
      write_reg(REG_KD_GAIN, kd);
      write_reg(REG_MAX_PWM, ceiling);
      write_reg(REG_DEADBAND, deadband);
      settings_applied++;
   endtask

   // With no gap, tvalid stays high and the next call puts its word straight on.
   task automatic send_word(input logic op, input int cnt, input logic rev,
                            input int tgt, input int gap);
      logic [REQ_W-1:0] word;
      word = '0;
      word[COUNT_BITS-1:0] = cnt[COUNT_BITS-1:0];
      word[COUNT_BITS] = rev;
      word[COUNT_BITS+24:COUNT_BITS+1] = tgt[23:0];
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic tick(input int cnt, input logic rev, input int tgt);
      send_word(OP_TICK, cnt, rev, tgt, pick_gap());
   endtask

   task automatic finish_phase();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (drives_outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   // Most words follow a motor whose rate drifts, so the encoder count moves
   // consistently with the direction and wraps now and then; the rest is noise
   // and the occasional controller clear.
   task automatic run_random_phase(input int words, input bit calm);
      int k, r, cnt, tgt;
      logic op, rev;
      for (k = 0; k < words; k++) begin
         r = $urandom_range(0, 99);
         op = OP_TICK;
         cnt = $urandom_range(0, (1 << COUNT_BITS) - 1);
         rev = 1'($urandom_range(0, 1));
         tgt = $urandom;
         if (r < 3) begin
            op = OP_CLEAR;
         end else if (r >= 15) begin
            if ($urandom_range(0, 19) == 0) begin
               motor_rate = $urandom_range(0, 6000) - 3000;
            end else begin
               motor_rate = motor_rate + $urandom_range(0, 40) - 20;
               if (motor_rate > 600)
                  motor_rate = 600;
               else if (motor_rate < -600)
                  motor_rate = -600;
            end
            enc_pos = (enc_pos + motor_rate) & ((1 << COUNT_BITS) - 1);
            cnt = enc_pos;
            rev = (motor_rate < 0);
            if ($urandom_range(0, 9) == 0)
               tgt = $urandom_range(0, 1600000) - 800000;
            else
               tgt = motor_rate * 256 + $urandom_range(0, 4095) - 2048;
         end
         send_word(op, cnt, rev, tgt, calm ? 0 : pick_gap());
      end
   endtask

   // Result side: random holds, plus one long hold each time stall_seq moves.
   initial begin
      int hold;
      int stall_done;
      stall_done = 0;
      forever begin
         @(posedge clock);
         hold = 0;
         if (stall_seq != stall_done) begin
            stall_done = stall_seq;
            hold = LONG_HOLD;
         end else if (!calm_rsp && $urandom_range(0, 2) == 0) begin
            hold = pick_gap();
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      int phase, idx;
      bit calm;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      apply_settings(16'h0180, 16'h0020, 16'h0040, 16'hFFFF, 16'h0020);
      tick(0, 1'b0, 0);
      tick(100, 1'b0, 8388607);
      tick(16383, 1'b0, -8388608);
      tick(10, 1'b0, 2816);           // forward wrap
      tick(16300, 1'b1, -24064);      // reverse wrap
      tick(16000, 1'b1, -76800);
      tick(1000, 1'b0, 0);            // big forward drop, still no wrap
      tick(16383, 1'b0, 0);
      tick(383, 1'b0, 0);             // drop of exactly the wrap jump
      tick(16383, 1'b1, 0);           // rise of exactly the wrap jump
      tick(0, 1'b1, 0);
      tick(16383, 1'b1, 0);
      tick(0, 1'b0, 0);
      send_word(OP_CLEAR, 16383, 1'b1, -1, pick_gap());
      tick(5, 1'b0, 256);
      tick(6, 1'b0, 512);             // duty under the deadband
      repeat (5) tick(6, 1'b0, 8388607);
      repeat (2) tick(6, 1'b0, -8388608);
      send_word(OP_CLEAR, 0, 1'b0, 0, pick_gap());
      finish_phase();

      // Zero ceiling and a full deadband; writes to unused addresses must not land.
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
      for (idx = REG_DEADBAND + 1; idx < 8; idx++)
         write_reg(idx[2:0], 16'($urandom_range(0, 65535)));
      tick(200, 1'b0, 8388607);
      tick(9000, 1'b0, 100000);
      tick(100, 1'b1, -8388608);
      finish_phase();

      apply_settings(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
      tick(300, 1'b0, 8388607);
      tick(200, 1'b0, -8388608);
      finish_phase();

      for (phase = 0; phase < 14; phase++) begin
         calm = (phase % 4 == 1) || phase == 3 || phase == 10;
         calm_rsp <= (phase % 4 == 1);
         if (phase == 3 || phase == 10)
            stall_seq <= stall_seq + 1;
         apply_settings(pick_gain(), pick_gain(), pick_gain(),
                        pick_ceiling(), pick_deadband());
         run_random_phase(100, calm);
         finish_phase();
      end

      repeat (10) @(posedge clock);
      $display("Run: %0d words over %0d register settings, %0d controller clears, %0d wraps.",
               words_seen, settings_applied, resets_seen, wraps_seen);
      $display("Run: %0d drive commands compared, %0d of them braking.",
               drives_compared, brakes_seen);
      if (mismatches == 0 && drives_outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
